// ----- hdl/b32m_pkg.sv -----
// shared types, constants and checksum helpers for the bech32m address encoder
package b32m_pkg;

	localparam int HRP_MAX_DEF     = 83;
	localparam int PAYLOAD_MAX_DEF = 74;
	localparam int ENCODED_MAX_DEF = 90;

	localparam int HRP_CNT_W = 7;
	localparam int PAY_CNT_W = 7;
	localparam int TOTAL_W   = 9;
	localparam int CS_W      = 30;

	localparam logic [CS_W-1:0] BECH32M_CONST = 30'h2bc830a3;
	localparam logic [CS_W-1:0] GEN0 = 30'h3b6a57b2;
	localparam logic [CS_W-1:0] GEN1 = 30'h26508e6d;
	localparam logic [CS_W-1:0] GEN2 = 30'h1ea119fa;
	localparam logic [CS_W-1:0] GEN3 = 30'h3d4233dd;
	localparam logic [CS_W-1:0] GEN4 = 30'h2a1462b3;

	localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
	localparam logic [7:0] SEP_CHAR = 8'h31;

	typedef enum logic [1:0] {
		MODE_HRP  = 2'd0,
		MODE_BYTE = 2'd1,
		MODE_END  = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ERR_NONE         = 3'd0,
		ERR_BAD_CHAR     = 3'd1,
		ERR_HRP_LONG     = 3'd2,
		ERR_HRP_EMPTY    = 3'd3,
		ERR_PAYLOAD_LONG = 3'd4,
		ERR_TOTAL_LONG   = 3'd5
	} err_t;

	typedef enum logic [1:0] {
		PH_HRP  = 2'd0,
		PH_DATA = 2'd1,
		PH_DROP = 2'd2
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_FOLD_INIT,
		ST_FOLD_RUN,
		ST_SEP,
		ST_VER,
		ST_BYTE,
		ST_PAD,
		ST_CKGEN,
		ST_CKOUT
	} state_t;

	function automatic logic [CS_W-1:0] gen_step(input logic [CS_W-1:0] v);
		logic [CS_W-1:0] r;
		r = {v[24:0], 5'b00000};
		if (v[25]) r = r ^ GEN0;
		if (v[26]) r = r ^ GEN1;
		if (v[27]) r = r ^ GEN2;
		if (v[28]) r = r ^ GEN3;
		if (v[29]) r = r ^ GEN4;
		return r;
	endfunction

	function automatic logic [7:0] sym_char(input logic [4:0] s);
		return CHARSET[{~s, 3'b000} +: 8];
	endfunction

	// ceil(8*bytes/5) via reciprocal multiply, exact for up to 79 bytes (the result is 7 bits wide)
	function automatic logic [6:0] sym_count(input logic [PAY_CNT_W-1:0] b);
		logic [9:0]  x;
		logic [17:0] p;
		x = 10'({b, 3'b000}) + 10'd4;
		p = 18'(x) * 18'd205;
		return p[16:10];
	endfunction

endpackage

// ----- hdl/bech32m_address_encoder_core.sv -----
// bech32m address encoder top level: sequencer, checksum and output register
// An item is taken only while the block is idle. An hrp character passes through
// dispatch only; a payload byte through dispatch, one step per output symbol and a
// leftover update; an end item through dispatch, a pad symbol when bits are left
// over, six checksum rounds and six checksum characters. The first payload byte or
// end item of a message also walks the hrp store through its single read port,
// then emits the separator and version. Every emitted character waits for the
// output register to be free, so a stalled consumer adds its stall cycles.
module bech32m_address_encoder_core #(
	parameter int HRP_MAX     = b32m_pkg::HRP_MAX_DEF,
	parameter int PAYLOAD_MAX = b32m_pkg::PAYLOAD_MAX_DEF,
	parameter int ENCODED_MAX = b32m_pkg::ENCODED_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [4:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [7:0] value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] character,
	output logic       last,
	output logic [2:0] error
);

	localparam int HRP_AW = (HRP_MAX > 1) ? $clog2(HRP_MAX) : 1;
	localparam int HCW    = b32m_pkg::HRP_CNT_W;
	localparam int PCW    = b32m_pkg::PAY_CNT_W;
	localparam int TW     = b32m_pkg::TOTAL_W;
	localparam int CW     = b32m_pkg::CS_W;

	b32m_pkg::state_t state_q, state_d;
	b32m_pkg::phase_t phase_q;

	logic [4:0]     witness_version_q;
	logic [1:0]     mode_q;
	logic [7:0]     value_q;
	logic [CW-1:0]  cs_q;
	logic [HCW-1:0] hrp_count_q;
	logic [PCW-1:0] payload_count_q;
	logic [3:0]     lb_q;
	logic [2:0]     lc_q;
	logic [11:0]    acc_q;
	logic [3:0]     bits_q;
	logic [HCW-1:0] fold_q;
	logic [2:0]     k_q;

	logic       out_valid_q;
	logic [7:0] character_q;
	logic       last_q;
	logic [2:0] error_q;

	logic             slot_free;
	logic             is_none, in_drop, is_hrp_char, is_end;
	logic             hrp_full, bad_char, too_long;
	logic [PCW-1:0]   sym_bytes;
	logic [TW-1:0]    total;
	b32m_pkg::err_t   disp_err;
	logic             disp_emit;
	logic [HCW-1:0]   fold_next;
	logic [4:0]       byte_sym, pad_sym;

	logic           emit;
	logic [7:0]     emit_char;
	logic           emit_last;
	b32m_pkg::err_t emit_err;
	logic           restart;
	logic           mem_wr_en, mem_rd_en;
	logic [HRP_AW-1:0] mem_rd_addr;
	logic [4:0]     mem_rd_data;

	assign slot_free   = !out_valid_q || out_ready;
	assign is_none     = mode_q == b32m_pkg::MODE_NONE;
	assign in_drop     = phase_q == b32m_pkg::PH_DROP;
	assign is_end      = mode_q == b32m_pkg::MODE_END;
	assign is_hrp_char = (mode_q == b32m_pkg::MODE_HRP) && (phase_q == b32m_pkg::PH_HRP);
	assign hrp_full    = hrp_count_q >= HCW'(HRP_MAX);
	assign bad_char    = (value_q < 8'd33) || (value_q > 8'd126)
		|| (value_q inside {[8'h41:8'h5a]});
	assign sym_bytes   = is_end ? payload_count_q : payload_count_q + PCW'(1);
	assign total       = TW'(hrp_count_q) + TW'(b32m_pkg::sym_count(sym_bytes)) + TW'(8);
	assign too_long    = total > TW'(ENCODED_MAX);
	assign fold_next   = fold_q + HCW'(1);
	assign byte_sym    = 5'(acc_q >> (bits_q - 4'd5));
	assign pad_sym     = 5'({1'b0, lb_q} << (3'd5 - lc_q));

	always_comb begin
		if (is_hrp_char) begin
			if (hrp_full) begin
				disp_err = b32m_pkg::ERR_HRP_LONG;
			end else if (bad_char) begin
				disp_err = b32m_pkg::ERR_BAD_CHAR;
			end else begin
				disp_err = b32m_pkg::ERR_NONE;
			end
		end else if (hrp_count_q == '0) begin
			disp_err = b32m_pkg::ERR_HRP_EMPTY;
		end else if (!is_end && payload_count_q >= PCW'(PAYLOAD_MAX)) begin
			disp_err = b32m_pkg::ERR_PAYLOAD_LONG;
		end else if (too_long) begin
			disp_err = b32m_pkg::ERR_TOTAL_LONG;
		end else begin
			disp_err = b32m_pkg::ERR_NONE;
		end
	end

	assign disp_emit = !is_none && !in_drop
		&& (is_hrp_char || disp_err != b32m_pkg::ERR_NONE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			b32m_pkg::ST_IDLE: begin
				if (in_valid) state_d = b32m_pkg::ST_DISPATCH;
			end
			b32m_pkg::ST_DISPATCH: begin
				if (is_none || in_drop) begin
					state_d = b32m_pkg::ST_IDLE;
				end else if (disp_emit) begin
					if (slot_free) state_d = b32m_pkg::ST_IDLE;
				end else if (phase_q == b32m_pkg::PH_HRP) begin
					state_d = b32m_pkg::ST_FOLD_INIT;
				end else if (is_end) begin
					state_d = b32m_pkg::ST_PAD;
				end else begin
					state_d = b32m_pkg::ST_BYTE;
				end
			end
			b32m_pkg::ST_FOLD_INIT: state_d = b32m_pkg::ST_FOLD_RUN;
			b32m_pkg::ST_FOLD_RUN: begin
				if (fold_next >= hrp_count_q) state_d = b32m_pkg::ST_SEP;
			end
			b32m_pkg::ST_SEP: begin
				if (slot_free) state_d = b32m_pkg::ST_VER;
			end
			b32m_pkg::ST_VER: begin
				if (slot_free) state_d = is_end ? b32m_pkg::ST_PAD : b32m_pkg::ST_BYTE;
			end
			b32m_pkg::ST_BYTE: begin
				if (bits_q < 4'd5) state_d = b32m_pkg::ST_IDLE;
			end
			b32m_pkg::ST_PAD: begin
				if (lc_q == '0 || slot_free) state_d = b32m_pkg::ST_CKGEN;
			end
			b32m_pkg::ST_CKGEN: begin
				if (k_q == 3'd5) state_d = b32m_pkg::ST_CKOUT;
			end
			b32m_pkg::ST_CKOUT: begin
				if (slot_free && k_q == 3'd5) state_d = b32m_pkg::ST_IDLE;
			end
			default: state_d = b32m_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		emit      = 1'b0;
		emit_char = '0;
		emit_last = 1'b0;
		emit_err  = b32m_pkg::ERR_NONE;
		restart   = 1'b0;
		mem_wr_en = 1'b0;
		mem_rd_en = 1'b0;
		mem_rd_addr = fold_next[HRP_AW-1:0];
		case (state_q)
			b32m_pkg::ST_DISPATCH: begin
				if (disp_emit) begin
					emit      = 1'b1;
					emit_err  = disp_err;
					emit_last = disp_err != b32m_pkg::ERR_NONE;
					emit_char = (disp_err == b32m_pkg::ERR_NONE) ? value_q : 8'd0;
					mem_wr_en = slot_free && is_hrp_char && disp_err == b32m_pkg::ERR_NONE;
					restart   = slot_free && is_end;
				end else if (!is_none && in_drop && is_end) begin
					restart = 1'b1;
				end
			end
			b32m_pkg::ST_FOLD_INIT: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = '0;
			end
			b32m_pkg::ST_FOLD_RUN: begin
				mem_rd_en = fold_next < hrp_count_q;
			end
			b32m_pkg::ST_SEP: begin
				emit      = 1'b1;
				emit_char = b32m_pkg::SEP_CHAR;
			end
			b32m_pkg::ST_VER: begin
				emit      = 1'b1;
				emit_char = b32m_pkg::sym_char(witness_version_q);
			end
			b32m_pkg::ST_BYTE: begin
				emit      = bits_q >= 4'd5;
				emit_char = b32m_pkg::sym_char(byte_sym);
			end
			b32m_pkg::ST_PAD: begin
				emit      = lc_q != '0;
				emit_char = b32m_pkg::sym_char(pad_sym);
			end
			b32m_pkg::ST_CKOUT: begin
				emit      = 1'b1;
				emit_char = b32m_pkg::sym_char(cs_q[29:25]);
				emit_last = k_q == 3'd5;
				restart   = slot_free && k_q == 3'd5;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	b32m_hrp_mem #(
		.DEPTH(HRP_MAX)
	) u_hrp_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (hrp_count_q[HRP_AW-1:0]),
		.wr_data (value_q[4:0]),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= b32m_pkg::ST_IDLE;
			witness_version_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) witness_version_q <= cfg_wr_data;
		end
	end

	// input item capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q  <= mode;
			value_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= b32m_pkg::PH_HRP;
			cs_q            <= CW'(1);
			hrp_count_q     <= '0;
			payload_count_q <= '0;
			lb_q            <= '0;
			lc_q            <= '0;
			fold_q          <= '0;
			k_q             <= '0;
		end else begin
			case (state_q)
				b32m_pkg::ST_DISPATCH: begin
					if (!is_none && !in_drop) begin
						if (is_hrp_char) begin
							if (slot_free) begin
								if (disp_err == b32m_pkg::ERR_NONE) begin
									cs_q <= b32m_pkg::gen_step(cs_q) ^ CW'(value_q[7:5]);
									hrp_count_q <= hrp_count_q + HCW'(1);
								end else begin
									phase_q <= b32m_pkg::PH_DROP;
								end
							end
						end else if (disp_err != b32m_pkg::ERR_NONE) begin
							if (slot_free) phase_q <= b32m_pkg::PH_DROP;
						end else if (!is_end) begin
							payload_count_q <= payload_count_q + PCW'(1);
						end
					end
				end
				b32m_pkg::ST_FOLD_INIT: begin
					cs_q   <= b32m_pkg::gen_step(cs_q);
					fold_q <= '0;
				end
				b32m_pkg::ST_FOLD_RUN: begin
					cs_q   <= b32m_pkg::gen_step(cs_q) ^ CW'(mem_rd_data);
					fold_q <= fold_next;
				end
				b32m_pkg::ST_VER: begin
					if (slot_free) begin
						cs_q    <= b32m_pkg::gen_step(cs_q) ^ CW'(witness_version_q);
						phase_q <= b32m_pkg::PH_DATA;
					end
				end
				b32m_pkg::ST_BYTE: begin
					if (bits_q >= 4'd5) begin
						if (slot_free) cs_q <= b32m_pkg::gen_step(cs_q) ^ CW'(byte_sym);
					end else begin
						lc_q <= bits_q[2:0];
						lb_q <= 4'(acc_q[3:0] & ~(4'hf << bits_q[2:0]));
					end
				end
				b32m_pkg::ST_PAD: begin
					if (lc_q != '0 && slot_free) begin
						cs_q <= b32m_pkg::gen_step(cs_q) ^ CW'(pad_sym);
					end
					k_q <= '0;
				end
				b32m_pkg::ST_CKGEN: begin
					if (k_q == 3'd5) begin
						cs_q <= b32m_pkg::gen_step(cs_q) ^ b32m_pkg::BECH32M_CONST;
						k_q  <= '0;
					end else begin
						cs_q <= b32m_pkg::gen_step(cs_q);
						k_q  <= k_q + 3'd1;
					end
				end
				b32m_pkg::ST_CKOUT: begin
					if (slot_free) begin
						cs_q <= {cs_q[24:0], 5'b00000};
						k_q  <= k_q + 3'd1;
					end
				end
				default: begin
					fold_q <= fold_q;
				end
			endcase
			if (restart) begin
				phase_q         <= b32m_pkg::PH_HRP;
				cs_q            <= CW'(1);
				hrp_count_q     <= '0;
				payload_count_q <= '0;
				lb_q            <= '0;
				lc_q            <= '0;
				k_q             <= '0;
			end
		end
	end

	// regrouping shifter for the byte in flight
	always_ff @(posedge clk) begin
		if (state_q == b32m_pkg::ST_DISPATCH) begin
			acc_q  <= {lb_q, value_q};
			bits_q <= {1'b0, lc_q} + 4'd8;
		end else if (state_q == b32m_pkg::ST_BYTE && bits_q >= 4'd5 && slot_free) begin
			bits_q <= bits_q - 4'd5;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && slot_free) begin
			character_q <= emit_char;
			last_q      <= emit_last;
			error_q     <= emit_err;
		end
	end

	assign in_ready  = state_q == b32m_pkg::ST_IDLE;
	assign out_valid = out_valid_q;
	assign character = character_q;
	assign last      = last_q;
	assign error     = error_q;

endmodule

// ----- hdl/b32m_hrp_mem.sv -----
// low-part store for hrp characters, one write and one registered read port
module b32m_hrp_mem #(
	parameter int DEPTH = b32m_pkg::HRP_MAX_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [4:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [4:0]    rd_data
);

	logic [4:0] mem [DEPTH];
	logic [4:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
